@@ rtl/dpfl_pkg.sv @@
// Shared types and constants of the demand paging block.
// No dependencies.
package dpfl_pkg;
   localparam int NumPages = 16;
   localparam int NumFrames = 4;
   localparam int PageWords = 8;
   localparam int WordBits = 32;
   localparam int PageBits = $clog2(NumPages);
   localparam int FrameBits = $clog2(NumFrames);
   localparam int OffBits = $clog2(PageWords);
   localparam int FwBits = FrameBits + OffBits;
   localparam int BwBits = PageBits + OffBits;
   localparam int StampBits = 32;

   typedef enum logic [1:0] {
      CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_QPAGE = 2'd2, CMD_QFRAME = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_BWRITE, ST_LOOKUP, ST_SCAN, ST_EVICT,
      ST_CRD, ST_CWR, ST_ACCESS, ST_FRD, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [FrameBits-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic busy;
      logic [FrameBits-1:0] best;
   } scan_sts_type;
endpackage

@@ rtl/dpfl_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module dpfl_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/dpfl_scan.sv @@
// Least-recently-used scan: one stamp compare per cycle over the frames.
// Depends on dpfl_pkg.
module dpfl_scan
   import dpfl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctl_type         ctl,
   input  logic [StampBits-1:0] stamp,
   output scan_sts_type         sts
);
   logic busy_ff, busy_in;
   logic [FrameBits-1:0] best_ff, best_in;
   logic [StampBits-1:0] min_ff, min_in;

   always_comb begin
      busy_in = busy_ff;
      best_in = best_ff;
      min_in = min_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         best_in = '0;
         min_in = stamp;
      end else if (busy_ff) begin
         if (min_ff > stamp) begin
            min_in = stamp;
            best_in = ctl.idx;
         end
         if (ctl.idx == FrameBits'(NumFrames - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      best_ff <= best_in;
      min_ff <= min_in;
   end

   assign sts.busy = busy_ff;
   assign sts.best = best_ff;
endmodule

@@ rtl/demand_paging_fifo_lru.sv @@
// Top level of the demand paging block with FIFO or LRU replacement.
// Depends on dpfl_pkg, dpfl_ram and dpfl_scan.
// After reset the block fills both word stores with ones.
// It then takes one request at a time and returns its response before it takes
// the next. A fault first copies the page in, word by word through the
// registered backing read. When all frames are in use it evicts a frame before
// the copy, in LRU mode after the stamp scan has found the least recently used
// frame. The stores each have one write port, and the stamp scan uses a single
// shared comparator.
module demand_paging_fifo_lru
   import dpfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], address[8:2], write_value[40:9], zeros[47:41]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], fault[32], victim_valid[33], victim_page[37:34],
   // entry_valid[38], entry_dirty[39], entry_frame[43:40], zeros[47:44]
   output logic [47:0] rsp_tdata
);
   state_type state_ff, state_in;
   logic mode_ff;
   cmd_type cmd_ff, cmd_in;
   logic [6:0] addr_ff, addr_in;
   logic [WordBits-1:0] wval_ff, wval_in;
   logic [NumPages-1:0] pv_ff, pv_in, pd_ff, pd_in;
   logic [FrameBits-1:0] pf_ff [NumPages];
   logic [FrameBits-1:0] fq_frame_ff [NumFrames];
   logic [PageBits-1:0] fq_page_ff [NumFrames];
   logic [PageBits-1:0] owner_ff [NumFrames];
   logic [StampBits-1:0] stamp_ff [NumFrames];
   logic [StampBits-1:0] cnt_ff;
   logic [FrameBits:0] filled_ff;
   logic [BwBits:0] clr_ff, clr_in;
   logic [OffBits:0] cp_ff, cp_in;
   logic [FrameBits-1:0] tf_ff, tf_in, si_ff, si_in;
   logic evict_ff, evict_in, fault_ff, fault_in;
   logic [PageBits-1:0] vic_ff, vic_in;
   logic [WordBits-1:0] data_ff, data_in;
   logic rv_ff, rv_in;
   logic [47:0] rsp_ff, rsp_in;

   logic [PageBits-1:0] page;
   logic [OffBits-1:0] off;
   logic b_we, f_we;
   logic [BwBits-1:0] b_wa, b_ra;
   logic [FwBits-1:0] f_wa, f_ra;
   logic [WordBits-1:0] b_wd, f_wd, b_rd, f_rd;
   scan_ctl_type sctl;
   scan_sts_type ssts;
   logic do_fifo, do_fill, do_acc;

   assign page = addr_ff[6:OffBits];
   assign off = addr_ff[OffBits-1:0];

   dpfl_ram #(.Width(WordBits), .Depth(NumPages * PageWords)) u_back (
      .clock, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
   dpfl_ram #(.Width(WordBits), .Depth(NumFrames * PageWords)) u_frame (
      .clock, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
   dpfl_scan u_scan (.clock, .reset, .ctl(sctl), .stamp(stamp_ff[si_ff]), .sts(ssts));

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      addr_in = addr_ff;
      wval_in = wval_ff;
      clr_in = clr_ff;
      cp_in = cp_ff;
      tf_in = tf_ff;
      si_in = si_ff;
      evict_in = evict_ff;
      fault_in = fault_ff;
      vic_in = vic_ff;
      data_in = data_ff;
      rv_in = rv_ff && !rsp_tready;
      rsp_in = rsp_ff;
      pv_in = pv_ff;
      pd_in = pd_ff;
      b_we = 1'b0;
      b_wa = {page, off};
      b_wd = wval_ff;
      b_ra = {page, cp_ff[OffBits-1:0]};
      f_we = 1'b0;
      f_wa = {tf_ff, off};
      f_wd = wval_ff;
      f_ra = {tf_ff, off};
      sctl.start = 1'b0;
      sctl.idx = si_ff;
      do_fifo = 1'b0;
      do_fill = 1'b0;
      do_acc = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            b_we = 1'b1;
            b_wa = clr_ff[BwBits-1:0];
            b_wd = '1;
            f_we = 1'b1;
            f_wa = clr_ff[FwBits-1:0];
            f_wd = '1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BwBits+1)'(NumPages * PageWords - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = cmd_type'(req_tdata[1:0]);
               addr_in = req_tdata[8:2];
               wval_in = req_tdata[40:9];
               evict_in = 1'b0;
               fault_in = 1'b0;
               vic_in = '0;
               data_in = '0;
               si_in = '0;
               state_in = ST_BWRITE;
            end
         end
         ST_BWRITE: begin
            b_we = (cmd_ff == CMD_WRITE);
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            unique case (cmd_ff)
               CMD_READ, CMD_WRITE: begin
                  tf_in = pf_ff[page];
                  cp_in = '0;
                  if (pv_ff[page]) begin
                     state_in = ST_ACCESS;
                  end else begin
                     fault_in = 1'b1;
                     if (filled_ff < (FrameBits+1)'(NumFrames)) begin
                        tf_in = filled_ff[FrameBits-1:0];
                        do_fill = 1'b1;
                        state_in = ST_CRD;
                     end else if (!mode_ff) begin
                        tf_in = fq_frame_ff[0];
                        vic_in = fq_page_ff[0];
                        do_fifo = 1'b1;
                        state_in = ST_EVICT;
                     end else begin
                        sctl.start = 1'b1;
                        si_in = FrameBits'(1);
                        state_in = ST_SCAN;
                     end
                  end
               end
               CMD_QPAGE: begin
                  state_in = ST_DONE;
               end
               CMD_QFRAME: begin
                  tf_in = addr_ff[OffBits +: FrameBits];
                  f_ra = {addr_ff[OffBits +: FrameBits], off};
                  state_in = ST_FRD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCAN: begin
            si_in = si_ff + 1'b1;
            if (si_ff == FrameBits'(NumFrames - 1)) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (mode_ff) begin
               tf_in = ssts.best;
               vic_in = owner_ff[ssts.best];
            end
            evict_in = 1'b1;
            pv_in[mode_ff ? owner_ff[ssts.best] : vic_ff] = 1'b0;
            pd_in[mode_ff ? owner_ff[ssts.best] : vic_ff] = 1'b0;
            state_in = ST_CRD;
         end
         ST_CRD: begin
            state_in = ST_CWR;
         end
         ST_CWR: begin
            f_we = 1'b1;
            f_wa = {tf_ff, cp_ff[OffBits-1:0]};
            f_wd = b_rd;
            cp_in = cp_ff + 1'b1;
            if (cp_ff == (OffBits+1)'(PageWords - 1)) begin
               pv_in[page] = 1'b1;
               state_in = ST_ACCESS;
            end else begin
               state_in = ST_CRD;
            end
         end
         ST_ACCESS: begin
            do_acc = 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               f_we = 1'b1;
               pd_in[page] = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            if (cmd_ff == CMD_READ || addr_ff[6:OffBits] < 4'(NumFrames)) begin
               data_in = f_rd;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_in = '0;
            rsp_in[31:0] = data_ff;
            rsp_in[32] = fault_ff;
            rsp_in[33] = evict_ff;
            rsp_in[37:34] = evict_ff ? 4'(vic_ff) : 4'd0;
            unique case (cmd_ff)
               CMD_READ, CMD_WRITE: begin
                  rsp_in[38] = 1'b1;
                  rsp_in[39] = pd_ff[page];
                  rsp_in[43:40] = 4'(tf_ff);
               end
               CMD_QPAGE: begin
                  rsp_in[38] = pv_ff[page];
                  rsp_in[39] = pd_ff[page];
                  rsp_in[43:40] = pv_ff[page] ? 4'(pf_ff[page]) : 4'(page);
               end
               default: ;
            endcase
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         mode_ff <= 1'b0;
         pv_ff <= '0;
         pd_ff <= '0;
         cnt_ff <= '0;
         filled_ff <= '0;
         for (int i = 0; i < NumPages; i++) begin
            pf_ff[i] <= '0;
         end
         for (int i = 0; i < NumFrames; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         pv_ff <= pv_in;
         pd_ff <= pd_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (do_fill) begin
            filled_ff <= filled_ff + 1'b1;
            stamp_ff[tf_in] <= cnt_ff;
         end
         if (state_ff == ST_CWR && state_in == ST_ACCESS) begin
            pf_ff[page] <= tf_ff;
         end
         if (do_acc) begin
            cnt_ff <= cnt_ff + 1'b1;
            stamp_ff[tf_ff] <= cnt_ff + 1'b1;
         end
      end
      if (do_fill) begin
         fq_frame_ff[tf_in] <= tf_in;
         fq_page_ff[tf_in] <= page;
         owner_ff[tf_in] <= page;
      end
      if (do_fifo) begin
         for (int i = 0; i < NumFrames - 1; i++) begin
            fq_frame_ff[i] <= fq_frame_ff[i + 1];
            fq_page_ff[i] <= fq_page_ff[i + 1];
         end
         fq_frame_ff[NumFrames - 1] <= fq_frame_ff[0];
         fq_page_ff[NumFrames - 1] <= page;
      end
      if (state_ff == ST_EVICT && mode_ff) begin
         owner_ff[ssts.best] <= page;
      end
      cmd_ff <= cmd_in;
      addr_ff <= addr_in;
      wval_ff <= wval_in;
      cp_ff <= cp_in;
      tf_ff <= tf_in;
      si_ff <= si_in;
      evict_ff <= evict_in;
      fault_ff <= fault_in;
      vic_ff <= vic_in;
      data_ff <= data_in;
      rsp_ff <= rsp_in;
   end
endmodule
